FILE: design/adaptive_gain_lowpass_filter_macros.svh
// ----------------------------------------------------------------------------
// Adaptive gain low-pass filter assertion macros
// Shared assertion forms for the checker of the filter ports.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_GAIN_LOWPASS_FILTER_MACROS_SVH
`define ADAPTIVE_GAIN_LOWPASS_FILTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AGL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AGL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/agl_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive gain low-pass filter package
// Register map, reset values and shared types of the filter.
// ----------------------------------------------------------------------------
package agl_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 32;
    localparam int GAIN_FRAC_BITS_DEF = 15;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 31;
    localparam int GAIN_OUT_W = 16;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CHANGE_THRESHOLD = 3'd0,
        CFG_COUNT_THRESHOLD  = 3'd1,
        CFG_COUNT_STEP       = 3'd2,
        CFG_GAIN_STEP        = 3'd3,
        CFG_GAIN_INITIAL     = 3'd4,
        CFG_GAIN_MAX         = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [30:0] change_threshold;
        logic [15:0] count_threshold;
        logic [7:0]  count_step;
        logic [15:0] gain_step;
        logic [15:0] gain_initial;
        logic [15:0] gain_max;
    } agl_cfg_t;

    localparam logic [30:0] CHANGE_THRESHOLD_RST = 31'd2560;
    localparam logic [15:0] COUNT_THRESHOLD_RST  = 16'd20;
    localparam logic [7:0]  COUNT_STEP_RST       = 8'd5;
    localparam logic [15:0] GAIN_STEP_RST        = 16'd6554;
    localparam logic [15:0] GAIN_INITIAL_RST     = 16'd6554;
    localparam logic [15:0] GAIN_MAX_RST         = 16'd31130;

    localparam logic [15:0] GAIN_RST  = 16'd6554;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

endpackage

FILE: design/adaptive_gain_lowpass_filter.sv
// ----------------------------------------------------------------------------
// Adaptive gain low-pass filter
// First-order low-pass filter whose blend gain grows over runs of large
// same-direction changes and falls back on a reversal of direction.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Content (lowest bits first)
//  s_*       in         sample, zero padded to whole bytes
//  m_*       out        filtered, gain_used, zero padded to whole bytes
//  cfg_*     in         register index and write data, no read-back
//
// Each item is held in the input register and is then blended and
// written to the result register, so one item is taken per cycle while
// the result is not stalled. The recurrence on the stored value and gain
// closes within the single step stage. Reset is synchronous and active
// low; it empties both registers and restores the filter state and
// registers. When the result is stalled, one further item is held in the
// input register before s_tready falls.
//
module adaptive_gain_lowpass_filter #(
    parameter int SAMPLE_WIDTH   = agl_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = agl_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    // Input channel.
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // s_tdata: sample.
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]     s_tdata,
    // Result channel.
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // m_tdata: filtered, gain_used.
    output logic [((SAMPLE_WIDTH + 16 + 7) / 8) * 8 - 1:0] m_tdata,
    // Configuration write port.
    input  logic                                          cfg_we,
    input  logic [agl_pkg::CFG_ADDR_W-1:0]                cfg_addr,
    input  logic [agl_pkg::CFG_DATA_W-1:0]                cfg_wdata
);
    import agl_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int MDW = ((SAMPLE_WIDTH + 16 + 7) / 8) * 8;

    agl_cfg_t cfg;

    // Input register.
    logic                 in_valid_reg, in_valid_next;
    logic signed [SW-1:0] in_sample_reg;

    // Result register.
    logic                        m_valid_reg, m_valid_next;
    logic signed [SW-1:0]        filtered_reg;
    logic [GAIN_OUT_W-1:0]       gain_used_reg;

    logic                        out_ready;
    logic                        advance;
    logic                        in_take;
    logic signed [SW-1:0]        step_filtered;
    logic [GAIN_OUT_W-1:0]       step_gain;

    // The result register can be loaded when it is empty or being drained,
    // and the input register can take an item whenever its item moves on.
    assign out_ready = !m_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign in_take   = s_tvalid && s_tready;

    agl_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    agl_step #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .sample    (in_sample_reg),
        .cfg       (cfg),
        .filtered  (step_filtered),
        .gain_used (step_gain)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_sample_reg <= $signed(s_tdata[SW-1:0]);
        end
        if (advance) begin
            filtered_reg  <= step_filtered;
            gain_used_reg <= step_gain;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = MDW'({gain_used_reg, filtered_reg});

endmodule

FILE: design/agl_cfg_regs.sv
// ----------------------------------------------------------------------------
// Adaptive gain low-pass filter configuration registers
// Write-only register file loaded from the configuration port.
// ----------------------------------------------------------------------------
module agl_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [agl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [agl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output agl_pkg::agl_cfg_t                 cfg
);
    import agl_pkg::*;

    agl_cfg_t cfg_reg;
    agl_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_CHANGE_THRESHOLD: cfg_next.change_threshold = cfg_wdata;
                CFG_COUNT_THRESHOLD:  cfg_next.count_threshold  = cfg_wdata[15:0];
                CFG_COUNT_STEP:       cfg_next.count_step       = cfg_wdata[7:0];
                CFG_GAIN_STEP:        cfg_next.gain_step        = cfg_wdata[15:0];
                CFG_GAIN_INITIAL:     cfg_next.gain_initial     = cfg_wdata[15:0];
                CFG_GAIN_MAX:         cfg_next.gain_max         = cfg_wdata[15:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.change_threshold <= CHANGE_THRESHOLD_RST;
            cfg_reg.count_threshold  <= COUNT_THRESHOLD_RST;
            cfg_reg.count_step       <= COUNT_STEP_RST;
            cfg_reg.gain_step        <= GAIN_STEP_RST;
            cfg_reg.gain_initial     <= GAIN_INITIAL_RST;
            cfg_reg.gain_max         <= GAIN_MAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/agl_step.sv
// ----------------------------------------------------------------------------
// Adaptive gain low-pass filter step
// Filter state and the combinational update of gain, run count and output.
// ----------------------------------------------------------------------------
module agl_step #(
    parameter int SAMPLE_WIDTH   = agl_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = agl_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 advance,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample,
    input  agl_pkg::agl_cfg_t                    cfg,
    output logic signed [SAMPLE_WIDTH-1:0]       filtered,
    output logic [agl_pkg::GAIN_OUT_W-1:0]       gain_used
);
    import agl_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int GFB = GAIN_FRAC_BITS;
    // Stored gain must also hold the 16-bit reset value.
    localparam int GRW = (GFB + 1 > 16) ? GFB + 1 : 16;
    localparam int GSW = GRW + 1;
    localparam int MW  = (SW + 1 > 31) ? SW + 1 : 31;
    localparam int PW  = SW + GFB + 2;
    localparam logic [GRW-1:0] GAIN_ONE = GRW'(1) << GFB;
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) << (GFB - 1);

    logic signed [SW-1:0] last_value_reg, last_value_next;
    logic                 last_dir_reg, last_dir_next;
    logic [15:0]          run_count_reg, run_count_next;
    logic [GRW-1:0]       gain_reg, gain_next;

    logic signed [SW:0]   diff;
    logic [SW:0]          mag;
    logic                 dir;
    logic                 big_change;
    logic [16:0]          count_sum;
    logic [15:0]          count_sat;
    logic [GRW-1:0]       cap;
    logic [GRW-1:0]       init_gain;
    logic [GSW-1:0]       gain_pre;
    logic [GRW-1:0]       gain_new;
    logic [GFB:0]         gain_mul;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_shift;
    logic signed [SW-1:0] blended;

    assign diff  = $signed({sample[SW-1], sample}) - $signed({last_value_reg[SW-1], last_value_reg});
    assign dir   = !diff[SW] && (diff != '0);
    assign mag   = diff[SW] ? -diff : diff;
    assign big_change = MW'(mag) > MW'(cfg.change_threshold);

    assign count_sum = {1'b0, run_count_reg} + 17'(cfg.count_step);
    assign count_sat = count_sum[16] ? COUNT_MAX : count_sum[15:0];

    assign cap       = (GRW'(cfg.gain_max) < GAIN_ONE) ? GRW'(cfg.gain_max) : GAIN_ONE;
    assign init_gain = (GRW'(cfg.gain_initial) < GAIN_ONE) ? GRW'(cfg.gain_initial) : GAIN_ONE;

    always_comb begin
        last_dir_next  = last_dir_reg;
        run_count_next = run_count_reg;
        gain_pre       = {1'b0, gain_reg};
        if (dir == last_dir_reg) begin
            if (big_change) begin
                run_count_next = count_sat;
            end
            if (run_count_next >= cfg.count_threshold) begin
                gain_pre = {1'b0, gain_reg} + GSW'(cfg.gain_step);
            end
        end else begin
            run_count_next = '0;
            gain_pre       = {1'b0, init_gain};
            last_dir_next  = dir;
        end
    end

    assign gain_new = (gain_pre > {1'b0, cap}) ? cap : gain_pre[GRW-1:0];

    // The capped gain never exceeds unity, so GFB + 1 bits carry it.
    assign gain_mul   = gain_new[GFB:0];
    assign prod       = $signed({1'b0, gain_mul}) * diff;
    assign prod_shift = (prod + ROUND_HALF) >>> GFB;
    assign blended    = last_value_reg + prod_shift[SW-1:0];

    always_comb begin
        if (last_value_reg == '0) begin
            // An empty store passes the sample through at unity gain.
            filtered        = sample;
            gain_used       = GAIN_ONE[GAIN_OUT_W-1:0];
            last_value_next = sample;
            gain_next       = gain_reg;
        end else begin
            filtered        = blended;
            gain_used       = gain_new[GAIN_OUT_W-1:0];
            last_value_next = blended;
            gain_next       = gain_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_value_reg <= '0;
            last_dir_reg   <= 1'b0;
            run_count_reg  <= '0;
            gain_reg       <= GRW'(GAIN_RST);
        end else if (advance) begin
            last_value_reg <= last_value_next;
            gain_reg       <= gain_next;
            if (last_value_reg != '0) begin
                last_dir_reg  <= last_dir_next;
                run_count_reg <= run_count_next;
            end
        end
    end

endmodule

FILE: design/agl_checker.sv
// ----------------------------------------------------------------------------
// Adaptive gain low-pass filter checker
// Port-level assertions on the filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "adaptive_gain_lowpass_filter_macros.svh"

module agl_checker #(
    parameter int SAMPLE_WIDTH   = agl_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = agl_pkg::GAIN_FRAC_BITS_DEF
) (
    input logic                                           aclk,
    input logic                                           aresetn,
    input logic                                           s_tready,
    input logic                                           m_tvalid,
    input logic                                           m_tready,
    input logic [((SAMPLE_WIDTH + 16 + 7) / 8) * 8 - 1:0] m_tdata
);
    import agl_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    // Largest gain that can appear on the result, unity or the 16-bit limit.
    localparam logic [16:0] GAIN_LIMIT =
        (GAIN_FRAC_BITS >= 16) ? 17'h0FFFF : (17'd1 << GAIN_FRAC_BITS);

    // A stalled result keeps its item.
    `AGL_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // The input side only stalls when both registers are full and the result waits.
    `AGL_ASSERT_SAME(a_stall_only_when_full, !s_tready, m_tvalid && !m_tready, "input stalled while result could drain")

    // The reported gain never exceeds unity.
    `AGL_ASSERT_SAME(a_gain_bounded, m_tvalid, ({1'b0, m_tdata[SW+15:SW]} <= GAIN_LIMIT), "gain above unity")

    // After a stall with the result waiting, both registers are still full, so the
    // input is ready exactly when the result is taken.
    `AGL_ASSERT_NEXT(a_stall_persists, !s_tready && !m_tready, m_tvalid && (s_tready == m_tready), "input stall released without drain")

endmodule

bind adaptive_gain_lowpass_filter agl_checker #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
) u_agl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
